// File: rtl/core/s83c_pkg.sv
// Shared types, constants and helpers for the 8.3 short-name converter.
package s83c_pkg;

  localparam int NAME_LEN = 11;
  localparam int BASE_LEN = 8;

  localparam logic [7:0] PAD_CHAR    = 8'h20;
  localparam logic [7:0] NUL_CHAR    = 8'h00;
  localparam logic [7:0] SLASH_CHAR  = 8'h2F;
  localparam logic [7:0] DOT_CHAR    = 8'h2E;
  localparam logic [7:0] LOWER_A     = 8'h61;
  localparam logic [7:0] LOWER_Z     = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [3:0] BASE_END = 4'(BASE_LEN);
  localparam logic [3:0] NAME_END = 4'(NAME_LEN);
  localparam logic [3:0] LAST_POS = 4'(NAME_LEN - 1);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FORBIDDEN = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef logic [NAME_LEN-1:0][7:0] name_t;

  // One job for the back end: a full name, or an error when status is not ok.
  typedef struct packed {
    name_t   name;
    status_t status;
    logic    slash;
  } job_t;

  function automatic logic is_forbidden(input logic [7:0] c);
    return c inside {8'h22, [8'h2A:8'h2C], 8'h2E, 8'h2F, [8'h3A:8'h3F],
                     [8'h5B:8'h5D], 8'h7C};
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= LOWER_A && c <= LOWER_Z) r = c - CASE_OFFSET;
    return r;
  endfunction

endpackage

// File: rtl/core/short_name_8_3_converter.sv
// A terminator or error byte pushes a job into the registered queue; its beats start at the queue head.
// Throughput: one path byte per cycle while the job queue has room.
// A finished name drains as 11 beats, an error as one beat; the back end sets this pace.
// Jobs wait in a QUEUE_DEPTH-entry queue, so bytes keep flowing during a drain.
// Reset clears the name to spaces, write position, discarding, queue and back-end position.
module short_name_8_3_converter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] name_char,
  output logic [3:0] char_pos,
  output logic [1:0] status,
  output logic       ended_by_slash,
  output logic       last
);

  s83c_pkg::job_t push_job, head;
  logic           push, pop, head_valid, queue_full;

  s83c_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_in    (char_in),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  s83c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head      (head),
    .not_empty (head_valid),
    .full      (queue_full)
  );

  s83c_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .name_char      (name_char),
    .char_pos       (char_pos),
    .status         (status),
    .ended_by_slash (ended_by_slash),
    .last           (last)
  );

endmodule

// File: rtl/core/s83c_front.sv
// Front end: takes path bytes, builds the padded name and classifies jobs.
module s83c_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_in,
  input  logic               queue_full,
  output logic               push,
  output s83c_pkg::job_t     push_job
);

  s83c_pkg::name_t name_store;
  logic [3:0]      write_index, write_index_next;
  logic [3:0]      field_end, field_end_next;
  logic            discarding, discarding_next;
  logic            accept, term, clear, store_en;
  logic [7:0]      char_up;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign term     = (char_in == s83c_pkg::NUL_CHAR) || (char_in == s83c_pkg::SLASH_CHAR);
  assign char_up  = s83c_pkg::to_upper(char_in);

  always_comb begin
    write_index_next = write_index;
    field_end_next   = field_end;
    discarding_next  = discarding;
    clear            = 1'b0;
    store_en         = 1'b0;
    push             = 1'b0;
    push_job.name    = name_store;
    push_job.status  = s83c_pkg::ST_OK;
    push_job.slash   = (char_in == s83c_pkg::SLASH_CHAR);
    if (discarding) begin
      // drop bytes until a terminator
      if (term) begin
        discarding_next = 1'b0;
        clear           = 1'b1;
      end
    end else if (term) begin
      push  = 1'b1;
      clear = 1'b1;
      if (write_index == 4'd0) begin
        push_job.status = s83c_pkg::ST_EMPTY;
        push_job.slash  = 1'b0;
      end
    end else if (char_in == s83c_pkg::DOT_CHAR && field_end == s83c_pkg::BASE_END) begin
      write_index_next = s83c_pkg::BASE_END;
      field_end_next   = s83c_pkg::NAME_END;
    end else if (s83c_pkg::is_forbidden(char_in)) begin
      push            = 1'b1;
      clear           = 1'b1;
      discarding_next = 1'b1;
      push_job.status = s83c_pkg::ST_FORBIDDEN;
      push_job.slash  = 1'b0;
    end else if (write_index >= field_end) begin
      push            = 1'b1;
      clear           = 1'b1;
      discarding_next = 1'b1;
      push_job.status = s83c_pkg::ST_TOO_LONG;
      push_job.slash  = 1'b0;
    end else begin
      store_en         = 1'b1;
      write_index_next = write_index + 4'd1;
    end
    if (clear) begin
      write_index_next = 4'd0;
      field_end_next   = s83c_pkg::BASE_END;
    end
    if (!accept) push = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= 4'd0;
      field_end   <= s83c_pkg::BASE_END;
      discarding  <= 1'b0;
    end else if (accept) begin
      write_index <= write_index_next;
      field_end   <= field_end_next;
      discarding  <= discarding_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && clear)) begin
      for (int i = 0; i < s83c_pkg::NAME_LEN; i++) name_store[i] <= s83c_pkg::PAD_CHAR;
    end else if (accept && store_en) begin
      name_store[write_index] <= char_up;
    end
  end

  a_index_in_field: assert property (@(posedge clk) disable iff (rst)
    write_index <= field_end)
    else $error("write index beyond field end");

  a_field_end_legal: assert property (@(posedge clk) disable iff (rst)
    field_end == s83c_pkg::BASE_END || field_end == s83c_pkg::NAME_END)
    else $error("field end holds an illegal value");

  a_no_push_when_discarding: assert property (@(posedge clk) disable iff (rst)
    discarding |-> !push)
    else $error("job pushed while discarding");

endmodule

// File: rtl/core/s83c_queue.sv
// Short job queue between the front end and the back end.
module s83c_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  s83c_pkg::job_t     push_job,
  input  logic               pop,
  output s83c_pkg::job_t     head,
  output logic               not_empty,
  output logic               full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  s83c_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count out of range");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty))
    else $error("pop from an empty queue");

endmodule

// File: rtl/core/s83c_back.sv
// Back end: turns queued jobs into result beats, one name byte per beat, or one beat for an error.
module s83c_back (
  input  logic               clk,
  input  logic               rst,
  input  s83c_pkg::job_t     head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         name_char,
  output logic [3:0]         char_pos,
  output logic [1:0]         status,
  output logic               ended_by_slash,
  output logic               last
);

  logic [3:0] pos, pos_next;
  logic       is_err, beat;

  assign out_valid = head_valid;
  assign is_err    = (head.status != s83c_pkg::ST_OK);
  assign beat      = out_valid && out_ready;
  assign pop       = beat && (is_err || pos == s83c_pkg::LAST_POS);

  always_comb begin
    if (is_err) begin
      name_char      = 8'd0;
      char_pos       = 4'd0;
      ended_by_slash = 1'b0;
      last           = 1'b1;
    end else begin
      name_char      = head.name[pos];
      char_pos       = pos;
      ended_by_slash = head.slash;
      last           = (pos == s83c_pkg::LAST_POS);
    end
    status = head.status;
  end

  always_comb begin
    pos_next = pos;
    if (beat) pos_next = pop ? 4'd0 : pos + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) pos <= 4'd0;
    else     pos <= pos_next;
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= s83c_pkg::LAST_POS)
    else $error("name position out of range");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_err) |-> (last && pos == 4'd0))
    else $error("error beat not a single final beat");

  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    pop |=> pos == 4'd0)
    else $error("position not restarted after a job");

endmodule
